// File: hdl/frame_receiver_checker_assert.svh
// Assertion macros for the frame receiver checker.
// Included by the top level; depends on nothing else.
`ifndef FRAME_RECEIVER_CHECKER_ASSERT_SVH
`define FRAME_RECEIVER_CHECKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define FRC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame receiver checker: assertion failed");

// Next-cycle implication, disabled while reset is low.
`define FRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame receiver checker: assertion failed");

`endif

// File: hdl/frc_pkg.sv
// Shared types and constants of the frame receiver checker.
// Depends on nothing; the top level, parser, result queue and bench import it.
`default_nettype none

package frc_pkg;

  // Header layout
  localparam int HDR_BYTES  = 56;
  localparam int HASH_BYTES = 52;

  // Hash start value (not the standard FNV-1a 64 offset basis)
  localparam logic [63:0] FNV_BASIS = 64'd1469598103934665603;

  // Byte counter saturates here
  localparam logic [32:0] POS_MAX = 33'h1_FFFF_FFFF;

  // Status codes
  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_TRUNCATED = 4'd1;
  localparam logic [3:0] ST_MAGIC     = 4'd2;
  localparam logic [3:0] ST_VERSION   = 4'd3;
  localparam logic [3:0] ST_TYPE      = 4'd4;
  localparam logic [3:0] ST_RESERVED  = 4'd5;
  localparam logic [3:0] ST_TOO_LONG  = 4'd6;
  localparam logic [3:0] ST_LENGTH    = 4'd7;
  localparam logic [3:0] ST_CHECKSUM  = 4'd8;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_CNT  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN   = 8'd3;

  // Configuration reset values
  localparam logic [15:0] TYPE_CNT_RST = 16'd21;
  localparam logic [31:0] MAX_LEN_RST  = 32'd65536;

  typedef struct packed {
    logic [31:0] magic;
    logic [15:0] version;
    logic [15:0] type_count;
    logic [31:0] max_len;
  } cfg_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [3:0]  status;
    logic [15:0] message_type;
    logic [31:0] frame_flags;
    logic [31:0] payload_length;
    logic [63:0] sequence_number;
    logic [63:0] coord_epoch;
    logic [63:0] worker_id;
    logic [63:0] worker_boot_id;
  } res_t;

  // Up to two results per accepted word: payload first, then status
  typedef struct packed {
    logic pay_valid;
    logic stat_valid;
    res_t pay;
    res_t stat;
  } push_t;

endpackage

`default_nettype wire

// File: hdl/frc_in_if.sv
// Input channel of the frame receiver checker: one frame byte per word.
// Depends on nothing.
`default_nettype none

interface frc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// File: hdl/frc_out_if.sv
// Result channel of the frame receiver checker: payload bytes and status words.
// Depends on nothing.
`default_nettype none

interface frc_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  payload_byte;
  logic [3:0]  status;
  logic [15:0] message_type;
  logic [31:0] frame_flags;
  logic [31:0] payload_length;
  logic [63:0] sequence_number;
  logic [63:0] coord_epoch;
  logic [63:0] worker_id;
  logic [63:0] worker_boot_id;

  modport source (
    output valid, input ready,
    output result_kind, output payload_byte, output status, output message_type,
    output frame_flags, output payload_length, output sequence_number,
    output coord_epoch, output worker_id, output worker_boot_id
  );
  modport sink (
    input valid, output ready,
    input result_kind, input payload_byte, input status, input message_type,
    input frame_flags, input payload_length, input sequence_number,
    input coord_epoch, input worker_id, input worker_boot_id
  );
endinterface

`default_nettype wire

// File: hdl/frame_receiver_checker.sv
// Top level of the frame receiver checker: configuration registers, frame parser
// and result queue. Depends on frc_pkg, frc_in_if, frc_out_if, the parser and queue.
`default_nettype none
`include "frame_receiver_checker_assert.svh"

// Takes a frame one byte per word and checks its 56-byte little-endian header
// (magic, version, type, reserved word, length limit) and the FNV-1a 64 checksum,
// folded to 32 bits, over header bytes 0-51 and the payload. Each word is decoded
// in the cycle it is accepted, so a byte can be taken every cycle; the shift-add
// FNV prime multiply and the status compare are combinational. Payload bytes of a
// frame whose header passed come out as payload words; the final byte also yields
// one status word with the decoded header fields, so that byte can make two words.
// Results go through a small queue (FIFO_DEPTH words, default 4); input is taken
// while at least two entries are free, so a rate of one byte per cycle holds as
// long as the sink takes a word per cycle. Configuration must be written through
// cfg_we/cfg_index/cfg_wdata only while the block is idle; this is not enforced.
module frame_receiver_checker #(
  parameter int FIFO_DEPTH = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  frc_in_if.sink                             in_ch,
  frc_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [frc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                   cfg_wdata
);
  import frc_pkg::*;

  localparam int LVL_W = $clog2(FIFO_DEPTH+1);

  cfg_t             cfg_r;
  push_t            push;
  res_t             head;
  logic [LVL_W-1:0] level;
  logic             in_fire, out_fire;

  // Hold configuration registers; ignore unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.magic      <= '0;
      cfg_r.version    <= '0;
      cfg_r.type_count <= TYPE_CNT_RST;
      cfg_r.max_len    <= MAX_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAGIC:    cfg_r.magic      <= cfg_wdata;
        CFG_VERSION:  cfg_r.version    <= cfg_wdata[15:0];
        CFG_TYPE_CNT: cfg_r.type_count <= cfg_wdata[15:0];
        CFG_MAX_LEN:  cfg_r.max_len    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Take a byte while two queue entries are free
  assign in_ch.ready = level <= LVL_W'(FIFO_DEPTH-2);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_ch.valid && out_ch.ready;

  frc_frame_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (in_fire),
    .data_byte(in_ch.data_byte),
    .last_byte(in_ch.last_byte),
    .cfg      (cfg_r),
    .push     (push)
  );

  frc_result_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .pop  (out_fire),
    .head (head),
    .level(level)
  );

  // Drive the result channel from the queue head
  assign out_ch.valid           = level != '0;
  assign out_ch.result_kind     = head.result_kind;
  assign out_ch.payload_byte    = head.payload_byte;
  assign out_ch.status          = head.status;
  assign out_ch.message_type    = head.message_type;
  assign out_ch.frame_flags     = head.frame_flags;
  assign out_ch.payload_length  = head.payload_length;
  assign out_ch.sequence_number = head.sequence_number;
  assign out_ch.coord_epoch     = head.coord_epoch;
  assign out_ch.worker_id       = head.worker_id;
  assign out_ch.worker_boot_id  = head.worker_boot_id;

  // Checks on the queue and the status path
  `FRC_ASSERT_NOW(a_level_bound, clk, rst_n, 1'b1, level <= LVL_W'(FIFO_DEPTH))
  `FRC_ASSERT_NOW(a_stat_on_last, clk, rst_n, push.stat_valid, in_fire && in_ch.last_byte)
  `FRC_ASSERT_NEXT(a_last_gives_out, clk, rst_n, in_fire && in_ch.last_byte, out_ch.valid)

endmodule

`default_nettype wire

// File: hdl/frc_fnv_step.sv
// One FNV-1a 64 step: xor in a byte, multiply by the FNV prime.
// Depends on nothing.
`default_nettype none

module frc_fnv_step (
  input  wire logic [63:0] hash_in,
  input  wire logic [7:0]  data_byte,
  output logic      [63:0] hash_out
);

  logic [63:0] x;

  // Prime is 2^40 + 2^8 + 0xB3, so the multiply is a sum of shifted copies
  assign x = hash_in ^ {56'd0, data_byte};
  assign hash_out = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4)
                  + (x << 1) + x;

endmodule

`default_nettype wire

// File: hdl/frc_frame_parser.sv
// Frame state, header decode and checks, hash and end-of-frame status.
// Depends on frc_pkg and frc_fnv_step.
`default_nettype none

module frc_frame_parser (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          fire,
  input  wire logic [7:0]    data_byte,
  input  wire logic          last_byte,
  input  wire frc_pkg::cfg_t cfg,
  output frc_pkg::push_t     push
);
  import frc_pkg::*;

  localparam logic [5:0] POS_MAGIC_END = 6'd3;
  localparam logic [5:0] POS_TYPE_END  = 6'd7;
  localparam logic [5:0] POS_FLAGS_END = 6'd11;
  localparam logic [5:0] POS_LEN_END   = 6'd15;
  localparam logic [5:0] POS_RSVD_END  = 6'd19;
  localparam logic [5:0] POS_WORDS     = 6'd20;
  localparam logic [5:0] POS_CKSUM     = 6'(HASH_BYTES);

  logic [32:0] pos_r;
  logic [63:0] hash_r, hash_nxt, hash_step;
  logic [3:0]  err_r, err_nxt;
  logic [15:0] type_r, type_nxt;
  logic [31:0] flags_r, flags_nxt;
  logic [31:0] len_r, len_nxt;
  logic [63:0] words_r [4];
  logic [63:0] words_nxt [4];
  logic [31:0] cksum_r, cksum_nxt;
  logic [31:0] cshift_r, cshift_nxt;

  logic [32:0] count;
  logic [5:0]  pos6, woff, coff;
  logic        in_hdr, in_shift, in_words, in_cksum;
  logic [31:0] fold;
  logic [3:0]  status;

  frc_fnv_step u_fnv (
    .hash_in  (hash_r),
    .data_byte(data_byte),
    .hash_out (hash_step)
  );

  assign pos6     = pos_r[5:0];
  assign in_hdr   = pos_r < 33'(HDR_BYTES);
  assign in_shift = pos_r < 33'(POS_WORDS);
  assign in_words = in_hdr && !in_shift && (pos6 < POS_CKSUM);
  assign in_cksum = in_hdr && (pos6 >= POS_CKSUM);
  assign woff     = pos6 - POS_WORDS;
  assign coff     = pos6 - POS_CKSUM;
  assign count    = (pos_r == POS_MAX) ? pos_r : pos_r + 33'd1;

  // Decode the current byte into the next frame state
  always_comb begin
    hash_nxt   = in_cksum ? hash_r : hash_step;
    err_nxt    = err_r;
    type_nxt   = type_r;
    flags_nxt  = flags_r;
    len_nxt    = len_r;
    cksum_nxt  = cksum_r;
    cshift_nxt = cshift_r;
    for (int i = 0; i < 4; i++) begin
      words_nxt[i] = words_r[i];
    end
    if (in_shift) begin
      cshift_nxt = {data_byte, cshift_r[31:8]};
      case (pos6)
        POS_MAGIC_END: begin
          if (cshift_nxt != cfg.magic && err_nxt == ST_OK) err_nxt = ST_MAGIC;
        end
        POS_TYPE_END: begin
          type_nxt = cshift_nxt[31:16];
          if (cshift_nxt[15:0] != cfg.version && err_nxt == ST_OK) err_nxt = ST_VERSION;
          if ((type_nxt == 16'd0 || type_nxt >= cfg.type_count) && err_nxt == ST_OK) begin
            err_nxt = ST_TYPE;
          end
        end
        POS_FLAGS_END: flags_nxt = cshift_nxt;
        POS_LEN_END:   len_nxt = cshift_nxt;
        POS_RSVD_END: begin
          if (cshift_nxt != 32'd0 && err_nxt == ST_OK) err_nxt = ST_RESERVED;
          if (len_r > cfg.max_len && err_nxt == ST_OK) err_nxt = ST_TOO_LONG;
        end
        default: ;
      endcase
    end else if (in_words) begin
      words_nxt[woff[4:3]][{woff[2:0], 3'b000} +: 8] = data_byte;
    end else if (in_cksum) begin
      cksum_nxt[{coff[1:0], 3'b000} +: 8] = data_byte;
    end
  end

  // Pick the first failure that applies at the end of the frame
  assign fold = hash_nxt[63:32] ^ hash_nxt[31:0];
  always_comb begin
    if (count < 33'(HDR_BYTES))                         status = ST_TRUNCATED;
    else if (err_nxt != ST_OK)                          status = err_nxt;
    else if (count != 33'(HDR_BYTES) + {1'b0, len_nxt}) status = ST_LENGTH;
    else if (fold != cksum_nxt)                         status = ST_CHECKSUM;
    else                                                status = ST_OK;
  end

  // Build the result words for this byte
  always_comb begin
    push = '0;
    push.pay_valid        = fire && !in_hdr && (err_r == ST_OK);
    push.pay.result_kind  = KIND_PAYLOAD;
    push.pay.payload_byte = data_byte;
    push.stat_valid       = fire && last_byte;
    push.stat.result_kind = KIND_STATUS;
    push.stat.status      = status;
    if (status != ST_TRUNCATED) begin
      push.stat.message_type    = type_nxt;
      push.stat.frame_flags     = flags_nxt;
      push.stat.payload_length  = len_nxt;
      push.stat.sequence_number = words_nxt[0];
      push.stat.coord_epoch     = words_nxt[1];
      push.stat.worker_id       = words_nxt[2];
      push.stat.worker_boot_id  = words_nxt[3];
    end
  end

  // Advance on each accepted word; clear after the final byte
  always_ff @(posedge clk) begin
    if (!rst_n || (fire && last_byte)) begin
      pos_r    <= '0;
      hash_r   <= FNV_BASIS;
      err_r    <= ST_OK;
      type_r   <= '0;
      flags_r  <= '0;
      len_r    <= '0;
      cksum_r  <= '0;
      cshift_r <= '0;
      for (int i = 0; i < 4; i++) begin
        words_r[i] <= '0;
      end
    end else if (fire) begin
      pos_r    <= count;
      hash_r   <= hash_nxt;
      err_r    <= err_nxt;
      type_r   <= type_nxt;
      flags_r  <= flags_nxt;
      len_r    <= len_nxt;
      cksum_r  <= cksum_nxt;
      cshift_r <= cshift_nxt;
      for (int i = 0; i < 4; i++) begin
        words_r[i] <= words_nxt[i];
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/frc_result_fifo.sv
// Small result queue: takes up to two result words a cycle, hands out one.
// Depends on frc_pkg.
`default_nettype none

module frc_result_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire frc_pkg::push_t push,
  input  wire logic           pop,
  output frc_pkg::res_t       head,
  output logic [$clog2(DEPTH+1)-1:0] level
);
  import frc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LVL_W = $clog2(DEPTH+1);

  res_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r, wr_ptr_nxt, rd_ptr_nxt, wr_second;
  logic [LVL_W-1:0] level_r, level_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH-1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign wr_second = push.pay_valid ? ptr_inc(wr_ptr_r) : wr_ptr_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    if (push.pay_valid)  wr_ptr_nxt = ptr_inc(wr_ptr_nxt);
    if (push.stat_valid) wr_ptr_nxt = ptr_inc(wr_ptr_nxt);
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    level_nxt  = level_r + LVL_W'(push.pay_valid) + LVL_W'(push.stat_valid)
               - LVL_W'(pop);
  end

  // Store incoming words; payload ahead of status
  always_ff @(posedge clk) begin
    if (push.pay_valid)  mem[wr_ptr_r]  <= push.pay;
    if (push.stat_valid) mem[wr_second] <= push.stat;
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  assign head  = mem[rd_ptr_r];
  assign level = level_r;

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking bench for frame_receiver_checker: builds framed byte streams, predicts
// payload and status words, and compares them with what the block returns.
// Depends on frc_pkg, frc_in_if, frc_out_if and the frame_receiver_checker RTL.
module tb_top;
  import frc_pkg::*;

  localparam logic [63:0] FNV_PRIME = 64'd1099511628211;
  // Index past the register file; decodes to nothing
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 8'd6;
  localparam int TIMEOUT_UNITS = 4_000_000;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_PRINTS = 200;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_word_t;

  typedef struct {
    logic [31:0]      magic;
    logic [15:0]      version;
    logic [15:0]      mtype;
    logic [31:0]      flags;
    logic [31:0]      declared;
    logic [31:0]      reserved;
    logic [3:0][63:0] words;
    int               body_len;
    int               cut;
    logic [31:0]      sum_flip;
  } frame_plan_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_wdata;

  frc_in_if  in_ch ();
  frc_out_if out_ch ();

  frame_receiver_checker i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Register copy as seen by the predictor
  logic [31:0] set_magic;
  logic [15:0] set_version;
  logic [15:0] set_type_count;
  logic [31:0] set_max_len;

  // Receive state of the predictor
  logic [32:0]      rx_pos;
  logic [63:0]      rx_hash;
  logic [3:0]       rx_err;
  logic [15:0]      rx_type;
  logic [31:0]      rx_flags;
  logic [31:0]      rx_len;
  logic [3:0][63:0] rx_words;
  logic [31:0]      rx_sum;
  logic [31:0]      rx_shift;

  frame_word_t frame_bytes[$];
  res_t        expected_results[$];
  int          words_in_flight = 0;
  int          words_queued = 0;
  int          results_seen = 0;
  int          mismatches = 0;
  int          send_gap = 0;
  int          take_stall = 0;
  bit          calm = 1'b0;
  logic        in_fire = 1'b0;

  function automatic logic [63:0] fnv_mix(logic [63:0] h, logic [7:0] b);
    return (h ^ {56'd0, b}) * FNV_PRIME;
  endfunction

  function automatic void clear_rx();
    rx_pos   = '0;
    rx_hash  = FNV_BASIS;
    rx_err   = ST_OK;
    rx_type  = '0;
    rx_flags = '0;
    rx_len   = '0;
    rx_words = '0;
    rx_sum   = '0;
    rx_shift = '0;
  endfunction

  function automatic void note_fail(logic [3:0] code);
    if (rx_err == ST_OK) rx_err = code;
  endfunction

  // Advance the frame state by one byte and queue the words it yields
  function automatic void predict_frame_byte(logic [7:0] b, logic last);
    res_t        r;
    logic [32:0] pos;
    logic [32:0] off;
    logic [31:0] folded;
    pos = rx_pos;
    if (pos < 33'd52 || pos >= 33'(HDR_BYTES)) rx_hash = fnv_mix(rx_hash, b);
    if (pos < 33'd20) begin
      rx_shift = {b, rx_shift[31:8]};
      case (pos)
        33'd3: begin
          if (rx_shift != set_magic) note_fail(ST_MAGIC);
        end
        33'd7: begin
          rx_type = rx_shift[31:16];
          if (rx_shift[15:0] != set_version) note_fail(ST_VERSION);
          if (rx_type == 16'd0 || rx_type >= set_type_count) note_fail(ST_TYPE);
        end
        33'd11: rx_flags = rx_shift;
        33'd15: rx_len = rx_shift;
        33'd19: begin
          if (rx_shift != 32'd0) note_fail(ST_RESERVED);
          if (rx_len > set_max_len) note_fail(ST_TOO_LONG);
        end
        default: ;
      endcase
    end else if (pos < 33'd52) begin
      off = pos - 33'd20;
      rx_words[off[4:3]][{off[2:0], 3'b000} +: 8] = b;
    end else if (pos < 33'(HDR_BYTES)) begin
      rx_sum[{pos[1:0], 3'b000} +: 8] = b;
    end else if (rx_err == ST_OK) begin
      r = '0;
      r.result_kind = KIND_PAYLOAD;
      r.payload_byte = b;
      expected_results = {expected_results, r};
    end
    if (rx_pos != POS_MAX) rx_pos = rx_pos + 33'd1;
    if (last) begin
      r = '0;
      r.result_kind = KIND_STATUS;
      if (rx_pos < 33'(HDR_BYTES)) begin
        r.status = ST_TRUNCATED;
      end else begin
        folded = rx_hash[63:32] ^ rx_hash[31:0];
        if (rx_err != ST_OK) r.status = rx_err;
        else if (rx_pos != 33'(HDR_BYTES) + {1'b0, rx_len}) r.status = ST_LENGTH;
        else if (folded != rx_sum) r.status = ST_CHECKSUM;
        else r.status = ST_OK;
        r.message_type    = rx_type;
        r.frame_flags     = rx_flags;
        r.payload_length  = rx_len;
        r.sequence_number = rx_words[0];
        r.coord_epoch     = rx_words[1];
        r.worker_id       = rx_words[2];
        r.worker_boot_id  = rx_words[3];
      end
      expected_results = {expected_results, r};
      clear_rx();
    end
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("mismatch at result %0d: %s got %h expected %h", results_seen, what, got, want);
  endtask

  // Compare one returned word with the oldest expectation
  task automatic check_result();
    res_t got;
    res_t want;
    got.result_kind     = out_ch.result_kind;
    got.payload_byte    = out_ch.payload_byte;
    got.status          = out_ch.status;
    got.message_type    = out_ch.message_type;
    got.frame_flags     = out_ch.frame_flags;
    got.payload_length  = out_ch.payload_length;
    got.sequence_number = out_ch.sequence_number;
    got.coord_epoch     = out_ch.coord_epoch;
    got.worker_id       = out_ch.worker_id;
    got.worker_boot_id  = out_ch.worker_boot_id;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected word, kind", 64'(got.result_kind), '0);
    end else begin
      want = expected_results.pop_front();
      if (got.result_kind !== want.result_kind)
        report_mismatch("result_kind", 64'(got.result_kind), 64'(want.result_kind));
      if (got.payload_byte !== want.payload_byte)
        report_mismatch("payload_byte", 64'(got.payload_byte), 64'(want.payload_byte));
      if (got.status !== want.status)
        report_mismatch("status", 64'(got.status), 64'(want.status));
      if (got.message_type !== want.message_type)
        report_mismatch("message_type", 64'(got.message_type), 64'(want.message_type));
      if (got.frame_flags !== want.frame_flags)
        report_mismatch("frame_flags", 64'(got.frame_flags), 64'(want.frame_flags));
      if (got.payload_length !== want.payload_length)
        report_mismatch("payload_length", 64'(got.payload_length),
                        64'(want.payload_length));
      if (got.sequence_number !== want.sequence_number)
        report_mismatch("sequence_number", got.sequence_number, want.sequence_number);
      if (got.coord_epoch !== want.coord_epoch)
        report_mismatch("coord_epoch", got.coord_epoch, want.coord_epoch);
      if (got.worker_id !== want.worker_id)
        report_mismatch("worker_id", got.worker_id, want.worker_id);
      if (got.worker_boot_id !== want.worker_boot_id)
        report_mismatch("worker_boot_id", got.worker_boot_id, want.worker_boot_id);
    end
    results_seen++;
  endtask

  // Sample config writes, accepted bytes and returned words
  always @(posedge clk) begin
    if (!rst_n) begin
      set_magic      = '0;
      set_version    = '0;
      set_type_count = TYPE_CNT_RST;
      set_max_len    = MAX_LEN_RST;
      clear_rx();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAGIC:    set_magic = cfg_wdata;
          CFG_VERSION:  set_version = cfg_wdata[15:0];
          CFG_TYPE_CNT: set_type_count = cfg_wdata[15:0];
          CFG_MAX_LEN:  set_max_len = cfg_wdata;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_frame_byte(in_ch.data_byte, in_ch.last_byte);
        words_in_flight--;
      end
      if (out_ch.valid && out_ch.ready) check_result();
    end
    in_fire <= rst_n && in_ch.valid && in_ch.ready;
  end

  // Mostly no gap, sometimes a short one, rarely a long one
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Present the next byte once the current word is taken
  always @(negedge clk) begin
    frame_word_t nxt;
    if (!in_ch.valid || in_fire) begin
      if (send_gap > 0 || frame_bytes.size() == 0) begin
        if (send_gap > 0) send_gap--;
        in_ch.valid <= 1'b0;
      end else begin
        nxt = frame_bytes.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= nxt.data;
        in_ch.last_byte <= nxt.last;
        send_gap = pick_gap();
      end
    end
  end

  // Stall the result side at random
  always @(negedge clk) begin
    if (take_stall > 0) begin
      take_stall--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      take_stall = pick_gap();
    end
  end

  function automatic void queue_word(logic [7:0] b, logic last);
    frame_word_t w;
    w.data = b;
    w.last = last;
    frame_bytes = {frame_bytes, w};
    words_in_flight++;
    words_queued++;
  endfunction

  // Serialize a frame; the checksum is computed, then optionally corrupted
  function automatic void queue_frame(frame_plan_t p);
    logic [415:0] hdr;
    logic [7:0]   img[$];
    logic [63:0]  h;
    logic [31:0]  sum;
    int           total;
    hdr = {p.words, p.reserved, p.declared, p.flags, p.mtype, p.version, p.magic};
    h = FNV_BASIS;
    for (int i = 0; i < 52; i++) begin
      img = {img, hdr[8*i +: 8]};
      h = fnv_mix(h, hdr[8*i +: 8]);
    end
    for (int i = 0; i < 4; i++) img = {img, 8'h00};
    for (int i = 0; i < p.body_len; i++) begin
      img = {img, 8'($urandom_range(255))};
      h = fnv_mix(h, img[HDR_BYTES + i]);
    end
    sum = h[63:32] ^ h[31:0] ^ p.sum_flip;
    for (int i = 0; i < 4; i++) img[52 + i] = sum[8*i +: 8];
    total = (p.cut > 0) ? p.cut : img.size();
    for (int i = 0; i < total; i++) queue_word(img[i], i == total - 1);
  endfunction

  // Well-formed frame for the current settings
  function automatic frame_plan_t clean_plan(int body);
    frame_plan_t p;
    if (body > set_max_len) body = set_max_len;
    p.magic = set_magic;
    p.version = set_version;
    if (set_type_count <= 1) p.mtype = 16'd1;
    else if ($urandom_range(4) == 0) p.mtype = ($urandom_range(1) == 0) ? 16'd1 : set_type_count - 1;
    else p.mtype = 16'($urandom_range(set_type_count - 1, 1));
    p.flags = $urandom;
    p.declared = body;
    p.reserved = '0;
    for (int i = 0; i < 4; i++) p.words[i] = {$urandom, $urandom};
    p.body_len = body;
    p.cut = 0;
    p.sum_flip = '0;
    return p;
  endfunction

  // Mostly clean frames; the rest carry one or two kinds of damage or are noise
  function automatic void queue_random_frame();
    frame_plan_t p;
    int          body;
    int          n;
    body = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(12);
    p = clean_plan(body);
    case ($urandom_range(19))
      12: begin
        p.magic ^= 32'(1) << $urandom_range(31);
        if ($urandom_range(1) == 0) p.version ^= 16'(1) << $urandom_range(15);
      end
      13: p.version ^= 16'(1) << $urandom_range(15);
      14: begin
        if ($urandom_range(1) == 0 || set_type_count == 0) p.mtype = '0;
        else p.mtype = 16'($urandom_range(65535, set_type_count));
      end
      15: p.reserved = $urandom | (32'(1) << $urandom_range(31));
      16: begin
        if (set_max_len == '1) p.declared = p.body_len + 1;
        else if (set_max_len > 32'hFFFF_FFF0) p.declared = '1;
        else p.declared = set_max_len + 32'($urandom_range(3, 1));
      end
      17: begin
        if ($urandom_range(1) == 0 || p.declared == 0) p.body_len += $urandom_range(3, 1);
        else p.body_len = $urandom_range(p.declared - 1);
      end
      18: p.sum_flip = 32'(1) << $urandom_range(31);
      19: begin
        if ($urandom_range(1) == 0) begin
          p.cut = $urandom_range(HDR_BYTES - 1, 1);
        end else begin
          n = $urandom_range(90, 1);
          for (int i = 0; i < n; i++) queue_word(8'($urandom_range(255)), i == n - 1);
          return;
        end
      end
      default: ;
    endcase
    queue_frame(p);
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold until every byte is taken and every word is back, then let the block settle
  task automatic wait_idle();
    do @(negedge clk); while (words_in_flight != 0 || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic randomize_settings();
    logic [31:0] v;
    v = ($urandom_range(3) == 0) ? (($urandom_range(1) == 0) ? 32'h0 : 32'hFFFF_FFFF) : $urandom;
    write_reg(CFG_MAGIC, v);
    write_reg(CFG_VERSION, $urandom);
    v[31:16] = 16'($urandom);
    v[15:0] = ($urandom_range(1) == 0) ? 16'($urandom_range(40, 2)) : 16'($urandom_range(65535, 2));
    write_reg(CFG_TYPE_CNT, v);
    case ($urandom_range(3))
      0: v = 32'd0;
      1: v = $urandom_range(64, 8);
      2: v = MAX_LEN_RST;
      default: v = 32'hFFFF_FFFF;
    endcase
    write_reg(CFG_MAX_LEN, v);
  endtask

  initial begin
    frame_plan_t p;
    int          target;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    out_ch.ready    = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed frames under reset settings
    p = clean_plan(0); p.mtype = 16'd1; p.flags = '1; p.words = '1; queue_frame(p);
    p = clean_plan(3); p.mtype = TYPE_CNT_RST - 1; queue_frame(p);
    p = clean_plan(0); p.cut = 1; queue_frame(p);
    p = clean_plan(0); p.cut = HDR_BYTES - 1; queue_frame(p);
    p = clean_plan(2); p.magic = 32'hDEAD_BEEF; queue_frame(p);
    p = clean_plan(2); p.version = 16'h0001; queue_frame(p);
    p = clean_plan(2); p.mtype = 16'd0; queue_frame(p);
    p = clean_plan(2); p.mtype = TYPE_CNT_RST; queue_frame(p);
    p = clean_plan(2); p.reserved = 32'h8000_0000; queue_frame(p);
    p = clean_plan(0); p.declared = MAX_LEN_RST + 1; queue_frame(p);
    p = clean_plan(2); p.declared = 32'd5; queue_frame(p);
    p = clean_plan(4); p.declared = 32'd1; queue_frame(p);
    p = clean_plan(2); p.sum_flip = 32'h0000_0001; queue_frame(p);
    p = clean_plan(1); p.magic = '1; p.version = '1; p.reserved = 32'd1; queue_frame(p);
    wait_idle();

    // Upper extremes, a type count of one that admits no type, and no payload allowed
    write_reg(CFG_MAGIC, 32'hFFFF_FFFF);
    write_reg(CFG_VERSION, 32'hFFFF_FFFF);
    write_reg(CFG_TYPE_CNT, 32'd1);
    write_reg(CFG_MAX_LEN, 32'd0);
    p = clean_plan(0); queue_frame(p);
    p = clean_plan(0); p.body_len = 2; queue_frame(p);
    wait_idle();

    // Zero type count rejects every type; the stray index must not alias a register
    write_reg(CFG_TYPE_CNT, 32'd0);
    write_reg(CFG_UNUSED, 32'd21);
    p = clean_plan(0); p.mtype = 16'hFFFF; queue_frame(p);
    p = clean_plan(0); p.mtype = 16'd1; queue_frame(p);
    wait_idle();

    // Widest type range and length limit
    write_reg(CFG_MAGIC, 32'd0);
    write_reg(CFG_VERSION, 32'd0);
    write_reg(CFG_TYPE_CNT, 32'h0000_FFFF);
    write_reg(CFG_MAX_LEN, 32'hFFFF_FFFF);
    p = clean_plan(2); p.mtype = 16'hFFFE; queue_frame(p);
    p = clean_plan(2); p.declared = '1; queue_frame(p);
    p = clean_plan(1); p.mtype = 16'hFFFF; queue_frame(p);
    wait_idle();

    // Random phases; one runs with both sides streaming
    for (int ph = 0; ph < 4; ph++) begin
      calm = (ph == 2);
      randomize_settings();
      target = words_queued + 150;
      while (words_queued < target) queue_random_frame();
      wait_idle();
    end

    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #TIMEOUT_UNITS;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
